### hdl/tdpt_pkg.sv
// Package for the trial-division primality tester.
// Holds the small-prime table, the wheel offsets and the width defaults.
// No dependencies.
package tdpt_pkg;

  // Width of the number port and the default width of the tested number.
  localparam int NUMBER_W            = 32;
  localparam int NUMBER_BITS_DEFAULT = 32;

  // Primes below 100, tested directly and as first divisors.
  localparam int SMALL_PRIME_COUNT = 25;
  localparam int SMALL_PRIME_W     = 7;
  localparam int SMALL_IDX_W       = 5;
  localparam logic [SMALL_PRIME_W-1:0] SMALL_PRIMES [SMALL_PRIME_COUNT] = '{
    7'd2,  7'd3,  7'd5,  7'd7,  7'd11, 7'd13, 7'd17, 7'd19, 7'd23,
    7'd29, 7'd31, 7'd37, 7'd41, 7'd43, 7'd47, 7'd53, 7'd59, 7'd61,
    7'd67, 7'd71, 7'd73, 7'd79, 7'd83, 7'd89, 7'd97
  };
  localparam logic [SMALL_IDX_W-1:0] SMALL_IDX_LAST = SMALL_IDX_W'(SMALL_PRIME_COUNT - 1);

  // Mod-30 wheel: candidate divisors are base plus one of these offsets.
  localparam int WHEEL_SPOKES = 8;
  localparam int SPOKE_W      = 3;
  localparam int OFFSET_W     = 5;
  localparam logic [OFFSET_W-1:0] WHEEL_OFFSETS [WHEEL_SPOKES] = '{
    5'd0, 5'd6, 5'd10, 5'd12, 5'd16, 5'd18, 5'd22, 5'd28
  };
  localparam logic [SPOKE_W-1:0] SPOKE_LAST = SPOKE_W'(WHEEL_SPOKES - 1);
  localparam int WHEEL_START = 31;
  localparam int WHEEL_STEP  = 30;

endpackage

### hdl/tdpt_divider.sv
// Shared restoring divider: one quotient bit per cycle.
// Gives quotient and remainder of an NB-bit dividend by an NB-bit divisor.
// No package dependencies.
module tdpt_divider #(
  parameter int NB = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NB-1:0] dividend,
  input  logic [NB-1:0] divisor,
  output logic          done,
  output logic [NB-1:0] quotient,
  output logic [NB-1:0] remainder
);

  localparam int CNT_W = $clog2(NB);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [NB-1:0]    dvd;
  logic [NB-1:0]    dsr;
  logic [NB:0]      trial;
  logic             fits;

  // Shift in the next dividend bit and see whether the divisor fits.
  assign trial = {remainder, dvd[NB-1]};
  assign fits  = trial >= {1'b0, dsr};

  // Control: busy from a start until the last step, done pulses as the last step completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: one restoring step per cycle.
  always_ff @(posedge clk) begin
    if (!busy && start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
      quotient  <= '0;
      count     <= CNT_W'(NB - 1);
    end else if (busy) begin
      dvd       <= {dvd[NB-2:0], 1'b0};
      remainder <= fits ? NB'(trial - {1'b0, dsr}) : trial[NB-1:0];
      quotient  <= {quotient[NB-2:0], fits};
      count     <= count - 1'b1;
    end
  end

endmodule

### hdl/tdpt_seq.sv
// Sequencer of the primality tester: small-prime checks, then the wheel.
// Depends on tdpt_pkg and drives one tdpt_divider.
module tdpt_seq #(
  parameter int NB = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [NB-1:0] value_in,
  input  logic          res_ready,
  output logic          res_valid,
  output logic          res_flag
);
  import tdpt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SMALL  = 4'b0010,
    ST_WHEEL  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t               state;
  logic [NB-1:0]        value;
  logic [NB-1:0]        base;
  logic [SPOKE_W-1:0]   spoke;
  logic [SMALL_IDX_W-1:0] idx;
  logic                 div_start;
  logic [NB-1:0]        div_divisor;
  logic                 div_done;
  logic [NB-1:0]        div_quo;
  logic [NB-1:0]        div_rem;
  logic                 is_small_prime;
  logic [NB-1:0]        base_next;

  tdpt_divider #(.NB(NB)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (value),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Direct match against the primes below 100.
  always_comb begin
    is_small_prime = 1'b0;
    for (int k = 0; k < SMALL_PRIME_COUNT; k++) begin
      if (value_in == NB'(SMALL_PRIMES[k])) is_small_prime = 1'b1;
    end
  end

  assign base_next = NB'(base + NB'(WHEEL_STEP));
  assign in_stall  = (state != ST_IDLE);
  assign res_valid = (state == ST_FINISH) && res_ready;

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            value <= value_in;
            if (value_in <= NB'(1)) begin
              res_flag <= 1'b0;
              state    <= ST_FINISH;
            end else if (is_small_prime) begin
              res_flag <= 1'b1;
              state    <= ST_FINISH;
            end else begin
              idx         <= '0;
              div_divisor <= NB'(SMALL_PRIMES[0]);
              div_start   <= 1'b1;
              state       <= ST_SMALL;
            end
          end
        end
        ST_SMALL: begin
          if (div_done) begin
            if (div_rem == '0) begin
              res_flag <= 1'b0;
              state    <= ST_FINISH;
            end else if (idx == SMALL_IDX_LAST) begin
              base        <= NB'(WHEEL_START);
              spoke       <= '0;
              div_divisor <= NB'(WHEEL_START);
              div_start   <= 1'b1;
              state       <= ST_WHEEL;
            end else begin
              idx         <= idx + 1'b1;
              div_divisor <= NB'(SMALL_PRIMES[idx + 1'b1]);
              div_start   <= 1'b1;
            end
          end
        end
        ST_WHEEL: begin
          if (div_done) begin
            // The first spoke divides by base itself, so its quotient gives the bound.
            if (spoke == '0 && base > div_quo) begin
              res_flag <= 1'b1;
              state    <= ST_FINISH;
            end else if (div_rem == '0) begin
              res_flag <= 1'b0;
              state    <= ST_FINISH;
            end else if (spoke == SPOKE_LAST) begin
              base        <= base_next;
              spoke       <= '0;
              div_divisor <= base_next;
              div_start   <= 1'b1;
            end else begin
              spoke       <= spoke + 1'b1;
              div_divisor <= NB'(base + NB'(WHEEL_OFFSETS[spoke + 1'b1]));
              div_start   <= 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (res_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hdl/trial_division_primality_test.sv
// Trial-division primality tester on a mod-30 wheel.
// Takes one number word in, returns one prime_flag word out.
// Depends on tdpt_pkg, tdpt_seq and tdpt_divider.
//
// Usage: the input channel (in_valid, in_stall, number) takes one word when
// in_stall is low; in_stall stays high while the number is being tested.
// The low NUMBER_BITS bits of number are tested. The output channel
// (out_valid, out_stall, prime_flag) holds the word in a register until it
// is taken, and the next input word is accepted while it waits.
// 0 and 1, and the primes below 100, are answered without a division. Every
// other number goes through a restoring divider, one trial divisor at a
// time: 25 trials by the small primes, then 8 trials per wheel round
// until the wheel base squared exceeds the number. A 32-bit prime near the
// top of the range takes about 2200 wheel rounds. Reset clears the sequencer
// and the output register; the block is ready the cycle after reset. If the
// receiver stalls, the finished result waits in the sequencer until the
// output register is free.
module trial_division_primality_test #(
  parameter int NUMBER_BITS = tdpt_pkg::NUMBER_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tdpt_pkg::NUMBER_W-1:0] number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          prime_flag
);
  import tdpt_pkg::*;

  logic [63:0]          number_ext;
  logic [NUMBER_BITS-1:0] value_in;
  logic                 res_ready;
  logic                 res_valid;
  logic                 res_flag;

  // Keep only the low NUMBER_BITS bits of the number.
  assign number_ext = 64'(number);
  assign value_in   = number_ext[NUMBER_BITS-1:0];

  tdpt_seq #(.NB(NUMBER_BITS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value_in  (value_in),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_flag  (res_flag)
  );

  // Output register: free when empty or when its word is taken this cycle.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) prime_flag <= res_flag;
  end

endmodule

### hdl/tdpt_checker.sv
// Port-level checks for the trial-division primality tester.
// Depends only on the top-level ports; bound to the top level below.
module tdpt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic prime_flag
);

  // A stalled result word stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(prime_flag))
    else $error("stalled result word changed");

  // After a word is taken the tester is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // A new result word only appears while a test is in progress.
  a_result_from_test: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without a test in progress");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // The tester is ready right after reset.
  a_reset_ready: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind trial_division_primality_test tdpt_checker u_chk (.*);
